/* src/qrs_pkg.sv */
package qrs_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_SCAN,
        ST_NBR,
        ST_DECIDE
    } state_t;

    localparam logic REQ_STORE  = 1'b0;
    localparam logic REQ_LOCATE = 1'b1;

    localparam int NB_READS = 8;

    localparam logic [1:0] NB_LEFT       = 2'd0;
    localparam logic [1:0] NB_RIGHT      = 2'd1;
    localparam logic [1:0] NB_SPAN_LEFT  = 2'd2;
    localparam logic [1:0] NB_SPAN_RIGHT = 2'd3;

    typedef logic signed [15:0] sample_t;

endpackage

/* src/qrs_in_if.sv */
interface qrs_in_if;
    logic               valid;
    logic               ready;
    logic               req_type;
    logic signed [15:0] sample;
    logic        [8:0]  delay;

    modport source (output valid, req_type, sample, delay, input ready);
    modport sink (input valid, req_type, sample, delay, output ready);
endinterface

/* src/qrs_out_if.sv */
interface qrs_out_if;
    logic               valid;
    logic               ready;
    logic        [31:0] peak_sample_num;
    logic        [8:0]  peak_index;
    logic signed [15:0] peak_value;
    logic               chose_maximum;

    modport source (output valid, peak_sample_num, peak_index, peak_value, chose_maximum,
                    input ready);
    modport sink (input valid, peak_sample_num, peak_index, peak_value, chose_maximum,
                  output ready);
endinterface

/* src/qrs_ram.sv */
module qrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* src/qrs_main_peak_locator.sv */
// A store item is taken while idle and the next item may follow at once.
// A locate item first subtracts the ring length from delay+BACK_OFFSET+PRE_WINDOW until it
// is below the ring length, then does one ring read per cycle over the 2*HALF_WINDOW+1 window,
// eight neighbor reads, then a decision, which waits while a result is still held.
// Throughput is bounded by the single read port of the sample ring.
// After reset a clearing pass zeros every ring entry; no item is taken meanwhile.
module qrs_main_peak_locator
    import qrs_pkg::*;
#(
    parameter int BUF_LEN     = 512,
    parameter int HALF_WINDOW = 20,
    parameter int BACK_OFFSET = 14,
    parameter int PRE_WINDOW  = 16,
    parameter int SLOPE_SPAN  = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    qrs_in_if.sink    req_ch,
    qrs_out_if.source peak_ch
);

    localparam int IDX_W   = $clog2(BUF_LEN);
    localparam int WIN_LEN = 2 * HALF_WINDOW + 1;
    localparam int CNT_MAX = (WIN_LEN > NB_READS) ? WIN_LEN : NB_READS;
    localparam int CNT_W   = $clog2(CNT_MAX + 1);
    localparam int OFF_MAX = 511 + BACK_OFFSET + PRE_WINDOW;
    localparam int OFF_TOP = (OFF_MAX > BUF_LEN) ? OFF_MAX : BUF_LEN;
    localparam int OFF_W   = $clog2(OFF_TOP + 1);

    localparam logic [IDX_W:0]   LEN_X   = (IDX_W + 1)'(BUF_LEN);
    localparam logic [OFF_W-1:0] LEN_O   = OFF_W'(BUF_LEN);
    localparam logic [OFF_W-1:0] BACK_O  = OFF_W'(BACK_OFFSET + PRE_WINDOW);
    localparam logic [IDX_W-1:0] ONE_I   = IDX_W'(1);
    localparam logic [IDX_W-1:0] SPAN_I  = IDX_W'(SLOPE_SPAN);
    localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(BUF_LEN - 1);
    localparam logic [CNT_W-1:0] WIN_C   = CNT_W'(WIN_LEN);
    localparam logic [CNT_W-1:0] NB_C    = CNT_W'(NB_READS);

    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= LEN_X)
        begin
            s = s - LEN_X;
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [IDX_W-1:0] idx_sub(input logic [IDX_W-1:0] a,
                                                 input logic [IDX_W-1:0] b);
        logic [IDX_W:0] s;
        s = {1'b0, a} + LEN_X - {1'b0, b};
        if (s >= LEN_X)
        begin
            s = s - LEN_X;
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [16:0] abs_diff(input sample_t a, input sample_t b);
        logic signed [16:0] d;
        d = 17'(a) - 17'(b);
        return (d < 0) ? 17'(-d) : 17'(d);
    endfunction

    function automatic logic qualifies(input sample_t c, input sample_t left,
                                       input sample_t right);
        logic signed [16:0] l;
        logic signed [16:0] r;
        l = 17'(c) - 17'(left);
        r = 17'(right) - 17'(c);
        return !((l > 0 && r > 0) || (l < 0 && r < 0));
    endfunction

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [IDX_W-1:0]  wp_reg, wp_next;
    logic [31:0]       cnt_reg, cnt_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic [IDX_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              dv_reg, dv_next;
    logic              dfirst_reg, dfirst_next;
    logic [IDX_W-1:0]  didx_reg, didx_next;
    logic [2:0]        slot_reg, slot_next;
    sample_t           max_v_reg, max_v_next;
    sample_t           min_v_reg, min_v_next;
    logic [IDX_W-1:0]  max_i_reg, max_i_next;
    logic [IDX_W-1:0]  min_i_reg, min_i_next;
    sample_t           nb_reg [NB_READS];
    logic              out_valid_reg, out_valid_next;
    logic [31:0]       pos_reg, pos_next;
    logic [8:0]        pidx_reg, pidx_next;
    sample_t           pval_reg, pval_next;
    logic              pmax_reg, pmax_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    sample_t           wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    sample_t           rd_data;
    logic              in_fire;
    logic              load_out;

    logic              q_max, q_min, pick_max;
    logic [17:0]       s_max, s_min;
    logic [20:0]       s_max5, s_min4;
    logic [IDX_W-1:0]  win_i, nb_center, shift;

    qrs_ram #(
        .WIDTH (16),
        .DEPTH (BUF_LEN)
    ) u_ring (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign req_ch.ready            = (state_reg == ST_IDLE);
    assign in_fire                 = req_ch.valid && req_ch.ready;
    assign peak_ch.valid           = out_valid_reg;
    assign peak_ch.peak_sample_num = pos_reg;
    assign peak_ch.peak_index      = pidx_reg;
    assign peak_ch.peak_value      = pval_reg;
    assign peak_ch.chose_maximum   = pmax_reg;

    always_comb
    begin
        q_max    = qualifies(max_v_reg, nb_reg[0], nb_reg[1]);
        q_min    = qualifies(min_v_reg, nb_reg[4], nb_reg[5]);
        s_max    = 18'(abs_diff(max_v_reg, nb_reg[2])) + 18'(abs_diff(nb_reg[3], max_v_reg));
        s_min    = 18'(abs_diff(min_v_reg, nb_reg[6])) + 18'(abs_diff(nb_reg[7], min_v_reg));
        s_max5   = 21'(s_max) * 21'd5;
        s_min4   = 21'(s_min) * 21'd4;
        if (q_max && q_min)
        begin
            pick_max = (s_max5 >= s_min4);
        end
        else if (!q_max && q_min)
        begin
            pick_max = 1'b0;
        end
        else
        begin
            pick_max = 1'b1;
        end
        win_i = pick_max ? max_i_reg : min_i_reg;
        shift = idx_sub(wp_reg, win_i);
    end

    always_comb
    begin
        nb_center = (iss_reg < CNT_W'(NB_READS / 2)) ? max_i_reg : min_i_reg;
        case (iss_reg[1:0])
            NB_LEFT:       rd_addr = idx_sub(nb_center, ONE_I);
            NB_RIGHT:      rd_addr = idx_add(nb_center, ONE_I);
            NB_SPAN_LEFT:  rd_addr = idx_sub(nb_center, SPAN_I);
            default:       rd_addr = idx_add(nb_center, SPAN_I);
        endcase
        if (state_reg == ST_SCAN)
        begin
            rd_addr = addr_reg;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        wp_next     = wp_reg;
        cnt_next    = cnt_reg;
        off_next    = off_reg;
        addr_next   = addr_reg;
        iss_next    = iss_reg;
        dv_next     = 1'b0;
        dfirst_next = dfirst_reg;
        didx_next   = didx_reg;
        slot_next   = slot_reg;
        max_v_next  = max_v_reg;
        min_v_next  = min_v_reg;
        max_i_next  = max_i_reg;
        min_i_next  = min_i_reg;
        pos_next    = pos_reg;
        pidx_next   = pidx_reg;
        pval_next   = pval_reg;
        pmax_next   = pmax_reg;
        wr_en       = 1'b0;
        wr_addr     = wp_reg;
        wr_data     = req_ch.sample;
        rd_en       = 1'b0;
        load_out    = 1'b0;
        out_valid_next = (out_valid_reg && !peak_ch.ready);

        if (dv_reg && state_reg == ST_SCAN)
        begin
            if (dfirst_reg || rd_data > max_v_reg)
            begin
                max_v_next = rd_data;
                max_i_next = didx_reg;
            end
            if (dfirst_reg || rd_data < min_v_reg)
            begin
                min_v_next = rd_data;
                min_i_next = didx_reg;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                wr_data  = '0;
                clr_next = clr_reg + ONE_I;
                if (clr_reg == LAST_I)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (req_ch.req_type == REQ_STORE)
                    begin
                        wr_en    = 1'b1;
                        wp_next  = idx_add(wp_reg, ONE_I);
                        cnt_next = cnt_reg + 32'd1;
                    end
                    else
                    begin
                        off_next   = OFF_W'(req_ch.delay) + BACK_O;
                        state_next = ST_REDUCE;
                    end
                end
            end
            ST_REDUCE:
            begin
                if (off_reg >= LEN_O)
                begin
                    off_next = off_reg - LEN_O;
                end
                else
                begin
                    addr_next  = idx_sub(wp_reg, off_reg[IDX_W-1:0]);
                    iss_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (iss_reg < WIN_C)
                begin
                    rd_en       = 1'b1;
                    dv_next     = 1'b1;
                    didx_next   = addr_reg;
                    dfirst_next = (iss_reg == '0);
                    addr_next   = idx_add(addr_reg, ONE_I);
                    iss_next    = iss_reg + 1'b1;
                end
                else if (!dv_reg)
                begin
                    iss_next   = '0;
                    state_next = ST_NBR;
                end
            end
            ST_NBR:
            begin
                if (iss_reg < NB_C)
                begin
                    rd_en     = 1'b1;
                    dv_next   = 1'b1;
                    slot_next = iss_reg[2:0];
                    iss_next  = iss_reg + 1'b1;
                end
                else if (!dv_reg)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!out_valid_reg || peak_ch.ready)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    pos_next       = cnt_reg - {{(32 - IDX_W){1'b0}}, shift} + 32'd1;
                    pidx_next      = 9'(win_i);
                    pval_next      = pick_max ? max_v_reg : min_v_reg;
                    pmax_next      = pick_max;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wp_reg        <= '0;
            cnt_reg       <= '0;
            iss_reg       <= '0;
            dv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wp_reg        <= wp_next;
            cnt_reg       <= cnt_next;
            iss_reg       <= iss_next;
            dv_reg        <= dv_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        off_reg    <= off_next;
        addr_reg   <= addr_next;
        dfirst_reg <= dfirst_next;
        didx_reg   <= didx_next;
        slot_reg   <= slot_next;
        max_v_reg  <= max_v_next;
        min_v_reg  <= min_v_next;
        max_i_reg  <= max_i_next;
        min_i_reg  <= min_i_next;
        pos_reg    <= pos_next;
        pidx_reg   <= pidx_next;
        pval_reg   <= pval_next;
        pmax_reg   <= pmax_next;
        if (dv_reg && state_reg == ST_NBR)
        begin
            nb_reg[slot_reg] <= rd_data;
        end
    end

    a_store_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && req_ch.req_type == REQ_STORE) |=> (cnt_reg == $past(cnt_reg) + 32'd1))
        else $error("sample counter did not advance on a stored sample");

    a_ring_write_source: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (state_reg == ST_CLEAR || (in_fire && req_ch.req_type == REQ_STORE)))
        else $error("ring written outside clearing or a store");

    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> ($past(state_reg) == ST_DECIDE))
        else $error("result appeared without a decision");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !peak_ch.ready) |-> !load_out)
        else $error("pending result overwritten");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (iss_reg <= WIN_C))
        else $error("scan read count out of range");

endmodule
